/* rtl/scroll_camera_follow_unit_assert.svh */
// assertion macros for the scroll camera top level
// expects a clock and an active-low reset argument at each use
`ifndef SCROLL_CAMERA_FOLLOW_UNIT_ASSERT_SVH
`define SCROLL_CAMERA_FOLLOW_UNIT_ASSERT_SVH

// same-cycle implication
`define SCF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scroll camera check failed");

// next-cycle implication
`define SCF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scroll camera check failed");

`endif

/* rtl/scf_pkg.sv */
// types, codes and helpers for the scroll camera follow unit
// no dependencies
package scf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;

    localparam logic [11:0] RST_SCREEN_W = 12'd320;
    localparam logic [11:0] RST_SCREEN_H = 12'd240;
    localparam logic [7:0]  RST_TILE_W   = 8'd16;
    localparam logic [7:0]  RST_TILE_H   = 8'd16;
    localparam logic [11:0] RST_MAP_W    = 12'd64;
    localparam logic [11:0] RST_MAP_H    = 12'd64;
    localparam logic [15:0] RST_SPEED    = 16'd1229;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET_POS   = 3'd1,
        OP_FOLLOW    = 3'd2,
        OP_JUMP      = 3'd3,
        OP_RESET_POS = 3'd4
    } scf_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_W = 3'd0,
        REG_SCREEN_H = 3'd1,
        REG_TILE_W   = 3'd2,
        REG_TILE_H   = 3'd3,
        REG_MAP_W    = 3'd4,
        REG_MAP_H    = 3'd5,
        REG_SPEED    = 3'd6
    } scf_reg_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [7:0]  tile_width;
        logic [7:0]  tile_height;
        logic [11:0] map_width_tiles;
        logic [11:0] map_height_tiles;
        logic [15:0] speed;
    } scf_cfg_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               target_valid;
        logic [9:0]         frame_time;
    } scf_in_t;

    typedef struct packed {
        logic signed [15:0] cam_x;
        logic signed [15:0] cam_y;
        logic               moved;
    } scf_out_t;

    typedef struct packed {
        logic done;
        logic clr_jump;
    } scf_eng_res_t;

    // saturate to a signed range of the given bit count
    function automatic logic signed [33:0] scf_sat(input logic signed [33:0] v,
                                                   input int unsigned bits);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = (34'sd1 <<< (bits - 1)) - 34'sd1;
        lo = -hi - 34'sd1;
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

/* rtl/scroll_camera_follow_unit.sv */
// Scroll camera follow unit. One beat in, one beat out. Set position, follow, jump,
// reset position and a tick without a valid followed target skip the tick engine.
// A tick that chases the target runs the tick engine, which stops early when it
// is already on target or a jump is pending and snaps when the distance is below
// one step; a full step runs two 28-step restoring divisions and two 14-step
// square roots on the one shared subtractor. The input is not ready until the
// result is loaded into the output register; a result waiting there does not
// block the next beat from being accepted.
// top level: handshake, camera state and config registers; uses scf_pkg, scf_tick_engine
module scroll_camera_follow_unit #(
    parameter int COORD_BITS = scf_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scf_pkg::scf_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scf_pkg::scf_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [scf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import scf_pkg::*;

    localparam int C = COORD_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUSH} state_t;

    state_t              state_reg;
    scf_cfg_t            cfg_reg;
    scf_in_t             item_reg;
    logic signed [C-1:0] cam_x_reg, cam_y_reg, old_x_reg, old_y_reg;
    logic                following_reg, jump_reg;
    logic                m_valid_reg;
    scf_out_t            m_data_reg;

    logic                s_fire;
    logic                tick_go;
    logic                out_free;
    logic signed [33:0]  sat_x_c, sat_y_c;
    logic signed [31:0]  cx32_c, cy32_c;
    scf_eng_res_t        eng_res;
    logic signed [C-1:0] eng_x, eng_y;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign tick_go  = (s_data.operation == OP_TICK) && following_reg && s_data.target_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign sat_x_c  = scf_sat(34'(s_data.pos_x), C);
    assign sat_y_c  = scf_sat(34'(s_data.pos_y), C);
    assign cx32_c   = 32'(cam_x_reg);
    assign cy32_c   = 32'(cam_y_reg);

    scf_tick_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_fire && tick_go),
        .cfg          (cfg_reg),
        .item         (item_reg),
        .cam_x        (cam_x_reg),
        .cam_y        (cam_y_reg),
        .jump_pending (jump_reg),
        .res          (eng_res),
        .new_x        (eng_x),
        .new_y        (eng_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '{screen_width: RST_SCREEN_W, screen_height: RST_SCREEN_H,
                               tile_width: RST_TILE_W, tile_height: RST_TILE_H,
                               map_width_tiles: RST_MAP_W, map_height_tiles: RST_MAP_H,
                               speed: RST_SPEED};
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            following_reg <= 1'b0;
            jump_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (scf_reg_t'(cfg_index))
                    REG_SCREEN_W: cfg_reg.screen_width     <= cfg_wdata[11:0];
                    REG_SCREEN_H: cfg_reg.screen_height    <= cfg_wdata[11:0];
                    REG_TILE_W:   cfg_reg.tile_width       <= cfg_wdata[7:0];
                    REG_TILE_H:   cfg_reg.tile_height      <= cfg_wdata[7:0];
                    REG_MAP_W:    cfg_reg.map_width_tiles  <= cfg_wdata[11:0];
                    REG_MAP_H:    cfg_reg.map_height_tiles <= cfg_wdata[11:0];
                    REG_SPEED:    cfg_reg.speed            <= cfg_wdata;
                    default: ;
                endcase
            end

            // in the push state the output register is reloaded instead
            if (m_valid_reg && m_ready && state_reg != ST_PUSH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        item_reg  <= s_data;
                        old_x_reg <= cam_x_reg;
                        old_y_reg <= cam_y_reg;
                        state_reg <= tick_go ? ST_RUN : ST_PUSH;
                        case (s_data.operation)
                            OP_SET_POS: begin
                                cam_x_reg     <= sat_x_c[C-1:0];
                                cam_y_reg     <= sat_y_c[C-1:0];
                                following_reg <= 1'b0;
                            end
                            OP_FOLLOW: begin
                                following_reg <= 1'b1;
                                jump_reg      <= 1'b0;
                            end
                            OP_JUMP: begin
                                jump_reg <= 1'b1;
                            end
                            OP_RESET_POS: begin
                                cam_x_reg <= '0;
                                cam_y_reg <= '0;
                                jump_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    if (eng_res.done) begin
                        cam_x_reg <= eng_x;
                        cam_y_reg <= eng_y;
                        if (eng_res.clr_jump) begin
                            jump_reg <= 1'b0;
                        end
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_data_reg.cam_x <= cx32_c[15:0];
                        m_data_reg.cam_y <= cy32_c[15:0];
                        m_data_reg.moved <= (cam_x_reg != old_x_reg) ||
                                            (cam_y_reg != old_y_reg);
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `include "scroll_camera_follow_unit_assert.svh"

    // an accepted beat keeps the input closed for at least the next cycle
    `SCF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_ready)
    // the engine reports only while the top waits on it
    `SCF_ASSERT_IMPLY(a_done_in_run, aclk, aresetn, eng_res.done, state_reg == ST_RUN)
    // reset position leaves the camera at the origin with no jump pending
    `SCF_ASSERT_NEXT(a_reset_pos, aclk, aresetn,
                     s_fire && (s_data.operation == OP_RESET_POS),
                     cam_x_reg == '0 && cam_y_reg == '0 && !jump_reg)

endmodule

/* rtl/scf_tick_engine.sv */
// frame tick datapath: target clamp, distance, divide and square root
// one shared 32x32 multiplier and one shared wide subtractor; uses scf_pkg
module scf_tick_engine #(
    parameter int COORD_BITS = scf_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  scf_pkg::scf_cfg_t            cfg,
    input  scf_pkg::scf_in_t             item,
    input  logic signed [COORD_BITS-1:0] cam_x,
    input  logic signed [COORD_BITS-1:0] cam_y,
    input  logic                         jump_pending,
    output scf_pkg::scf_eng_res_t        res,
    output logic signed [COORD_BITS-1:0] new_x,
    output logic signed [COORD_BITS-1:0] new_y
);
    import scf_pkg::*;

    localparam int C          = COORD_BITS;
    localparam int DW         = C + 1;
    localparam int SQW        = 2 * C;
    localparam int LW         = 2 * C + 1;
    localparam int TPW        = 14;
    localparam int TP2W       = 2 * TPW;
    localparam int NW         = LW + TP2W - 1;
    localparam int DIV_STEPS  = TP2W;
    localparam int SQRT_STEPS = TPW;
    localparam int CNTW       = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_MX, S_MY, S_TP, S_DIFF, S_SQX, S_SQY, S_TP2, S_LEN, S_CMP,
        S_NLO, S_NHI, S_NSUM, S_DIV, S_SQRT
    } state_t;

    state_t                state_reg;
    logic signed [23:0]    txp_reg, typ_reg;
    logic signed [C-1:0]   tx_reg, ty_reg;
    logic [TPW-1:0]        tp_reg;
    logic [C-1:0]          ax_reg, ay_reg;
    logic                  xneg_reg, yneg_reg;
    logic [SQW-1:0]        ax2_reg, ay2_reg;
    logic [TP2W-1:0]       tp2_reg;
    logic [LW-1:0]         len2_reg;
    logic [63:0]           nlo_reg;
    logic [63:0]           prod_reg;
    logic [NW-1:0]         rem_reg, dsh_reg;
    logic [TP2W-1:0]       q_reg;
    logic [TPW-1:0]        root_reg, sx_reg;
    logic                  axis_reg;
    logic [CNTW-1:0]       cnt_reg;
    scf_eng_res_t          res_reg;
    logic signed [C-1:0]   new_x_reg, new_y_reg;

    logic signed [23:0]    txp_c, typ_c, mx_c, my_c, txc_c, tyc_c;
    logic signed [12:0]    hdiff_c;
    logic signed [33:0]    txs_c, tys_c;
    logic signed [DW-1:0]  xd_c, yd_c, xabs_c, yabs_c;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           ad2_c;
    logic [95:0]           n2_c;
    logic [NW-1:0]         rem2_c, sub_a, sub_b;
    logic [NW:0]           diff_c;
    logic                  borrow_c;
    logic                  q_bit_c;
    logic [TPW-1:0]        root_next_c;
    logic signed [DW-1:0]  sx_ext_c, sy_ext_c, stx_c, sty_c;

    always_comb begin
        // centred target before the map clamp
        txp_c = 24'(item.pos_x) + 24'($signed({1'b0, cfg.tile_width[7:1]}))
                - 24'($signed({1'b0, cfg.screen_width[11:1]}));
        if (txp_c < 0) begin
            txp_c = '0;
        end
        hdiff_c = $signed({1'b0, cfg.screen_height}) - $signed({5'b0, cfg.tile_height});
        typ_c = 24'(item.pos_y) - 24'(hdiff_c >>> 1);
        if (typ_c < 0) begin
            typ_c = '0;
        end

        mx_c  = $signed({4'b0, prod_reg[19:0]}) - $signed({12'b0, cfg.screen_width});
        my_c  = $signed({4'b0, prod_reg[19:0]}) - $signed({12'b0, cfg.screen_height});
        txc_c = (txp_reg > mx_c) ? mx_c : txp_reg;
        tyc_c = (typ_reg > my_c) ? my_c : typ_reg;
        txs_c = scf_sat(34'(txc_c), C);
        tys_c = scf_sat(34'(tyc_c), C);

        xd_c   = DW'(tx_reg) - DW'(cam_x);
        yd_c   = DW'(ty_reg) - DW'(cam_y);
        xabs_c = (xd_c < 0) ? -xd_c : xd_c;
        yabs_c = (yd_c < 0) ? -yd_c : yd_c;

        ad2_c = axis_reg ? 64'(ay2_reg) : 64'(ax2_reg);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MX: begin
                mul_a = 32'(cfg.map_width_tiles);
                mul_b = 32'(cfg.tile_width);
            end
            S_MY: begin
                mul_a = 32'(cfg.map_height_tiles);
                mul_b = 32'(cfg.tile_height);
            end
            S_TP: begin
                mul_a = 32'(cfg.speed);
                mul_b = 32'(item.frame_time);
            end
            S_SQX: begin
                mul_a = 32'(ax_reg);
                mul_b = 32'(ax_reg);
            end
            S_SQY: begin
                mul_a = 32'(ay_reg);
                mul_b = 32'(ay_reg);
            end
            S_TP2: begin
                mul_a = 32'(tp_reg);
                mul_b = 32'(tp_reg);
            end
            S_NLO: begin
                mul_a = 32'(tp2_reg);
                mul_b = ad2_c[31:0];
            end
            S_NHI: begin
                mul_a = 32'(tp2_reg);
                mul_b = ad2_c[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        n2_c = 96'(nlo_reg) + {prod_reg, 32'b0};

        // shared subtractor: restoring divide, then digit-by-digit square root
        rem2_c = {rem_reg[NW-3:0], q_reg[TP2W-1 -: 2]};
        if (state_reg == S_SQRT) begin
            sub_a = rem2_c;
            sub_b = NW'({root_reg, 2'b01});
        end else begin
            sub_a = rem_reg;
            sub_b = dsh_reg;
        end
        diff_c      = {1'b0, sub_a} - {1'b0, sub_b};
        borrow_c    = diff_c[NW];
        q_bit_c     = !borrow_c;
        root_next_c = {root_reg[TPW-2:0], !borrow_c};

        sx_ext_c = DW'($signed({1'b0, sx_reg}));
        sy_ext_c = DW'($signed({1'b0, root_next_c}));
        stx_c    = DW'(cam_x) + (xneg_reg ? -sx_ext_c : sx_ext_c);
        sty_c    = DW'(cam_y) + (yneg_reg ? -sy_ext_c : sy_ext_c);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    // the done pulse lasts the one cycle spent here after a result
                    res_reg <= '0;
                    if (start) begin
                        state_reg <= S_MX;
                    end
                end
                S_MX: begin
                    txp_reg   <= txp_c;
                    typ_reg   <= typ_c;
                    state_reg <= S_MY;
                end
                S_MY: begin
                    tx_reg    <= txs_c[C-1:0];
                    state_reg <= S_TP;
                end
                S_TP: begin
                    ty_reg    <= tys_c[C-1:0];
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    tp_reg   <= prod_reg[12 +: TPW];
                    ax_reg   <= xabs_c[C-1:0];
                    ay_reg   <= yabs_c[C-1:0];
                    xneg_reg <= xd_c < 0;
                    yneg_reg <= yd_c < 0;
                    if (xd_c == 0 && yd_c == 0) begin
                        // already on target: nothing moves, a pending jump stays
                        new_x_reg <= cam_x;
                        new_y_reg <= cam_y;
                        res_reg   <= '{done: 1'b1, clr_jump: 1'b0};
                        state_reg <= S_IDLE;
                    end else if (jump_pending) begin
                        new_x_reg <= tx_reg;
                        new_y_reg <= ty_reg;
                        res_reg   <= '{done: 1'b1, clr_jump: 1'b1};
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_SQX;
                    end
                end
                S_SQX: begin
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    ax2_reg   <= prod_reg[SQW-1:0];
                    state_reg <= S_TP2;
                end
                S_TP2: begin
                    ay2_reg   <= prod_reg[SQW-1:0];
                    state_reg <= S_LEN;
                end
                S_LEN: begin
                    tp2_reg   <= prod_reg[TP2W-1:0];
                    len2_reg  <= {1'b0, ax2_reg} + {1'b0, ay2_reg};
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (NW'(len2_reg) < NW'(tp2_reg)) begin
                        // closer than one step: snap
                        new_x_reg <= tx_reg;
                        new_y_reg <= ty_reg;
                        res_reg   <= '{done: 1'b1, clr_jump: 1'b0};
                        state_reg <= S_IDLE;
                    end else begin
                        axis_reg  <= 1'b0;
                        state_reg <= S_NLO;
                    end
                end
                S_NLO: begin
                    state_reg <= S_NHI;
                end
                S_NHI: begin
                    nlo_reg   <= prod_reg;
                    state_reg <= S_NSUM;
                end
                S_NSUM: begin
                    // quotient tp^2 * d^2 / len^2 stays below 2^28
                    rem_reg   <= n2_c[NW-1:0];
                    dsh_reg   <= {len2_reg, {(TP2W-1){1'b0}}};
                    q_reg     <= '0;
                    cnt_reg   <= CNTW'(DIV_STEPS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    q_reg   <= {q_reg[TP2W-2:0], q_bit_c};
                    dsh_reg <= dsh_reg >> 1;
                    if (cnt_reg == '0) begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= CNTW'(SQRT_STEPS - 1);
                        state_reg <= S_SQRT;
                    end else begin
                        if (!borrow_c) begin
                            rem_reg <= diff_c[NW-1:0];
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_SQRT: begin
                    rem_reg  <= borrow_c ? rem2_c : diff_c[NW-1:0];
                    root_reg <= root_next_c;
                    q_reg    <= q_reg << 2;
                    if (cnt_reg == '0) begin
                        if (!axis_reg) begin
                            sx_reg    <= root_next_c;
                            axis_reg  <= 1'b1;
                            state_reg <= S_NLO;
                        end else begin
                            new_x_reg <= stx_c[C-1:0];
                            new_y_reg <= sty_c[C-1:0];
                            res_reg   <= '{done: 1'b1, clr_jump: 1'b0};
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res   = res_reg;
    assign new_x = new_x_reg;
    assign new_y = new_y_reg;

endmodule

/* sim/scf_camera_tracker_pkg.sv */
// scoreboard for the scroll camera follow unit: tracks the camera and predicts each result
// depends on scf_pkg for the beat types, operation codes and register indexes
package scf_camera_tracker_pkg;
    import scf_pkg::*;

    class camera_tracker;
        int       view_w, view_h, tile_w, tile_h, map_w, map_h, speed;
        int       cam_x, cam_y;
        bit       following, jump_due;
        scf_out_t cam_due[$];
        int       errors;

        function new();
            view_w    = RST_SCREEN_W;
            view_h    = RST_SCREEN_H;
            tile_w    = RST_TILE_W;
            tile_h    = RST_TILE_H;
            map_w     = RST_MAP_W;
            map_h     = RST_MAP_H;
            speed     = RST_SPEED;
            cam_x     = 0;
            cam_y     = 0;
            following = 1'b0;
            jump_due  = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(scf_reg_t idx, int unsigned v);
            case (idx)
                REG_SCREEN_W: view_w = v & 'hFFF;
                REG_SCREEN_H: view_h = v & 'hFFF;
                REG_TILE_W:   tile_w = v & 'hFF;
                REG_TILE_H:   tile_h = v & 'hFF;
                REG_MAP_W:    map_w  = v & 'hFFF;
                REG_MAP_H:    map_h  = v & 'hFFF;
                REG_SPEED:    speed  = v & 'hFFFF;
                default: ;
            endcase
        endfunction

        function int sat16(int v);
            if (v < -32768) return -32768;
            if (v > 32767) return 32767;
            return v;
        endfunction

        // largest k <= tp with k*k*len2 <= (tp*ad)^2, i.e. floor(tp*ad/sqrt(len2))
        function longint unsigned axis_step(longint unsigned tp, longint unsigned ad,
                                            longint unsigned len2);
            longint unsigned n2, k, c;
            int bit_i;
            n2 = (tp * ad) * (tp * ad);
            k = 0;
            for (bit_i = 14; bit_i >= 0; bit_i--) begin
                c = k | (64'd1 << bit_i);
                if (c <= tp && n2 >= len2 * c * c) k = c;
            end
            return k;
        endfunction

        function void chase_target(int px, int py, bit tv, int ft);
            int tx, ty, lim, xd, yd;
            longint unsigned tp, ax, ay, len2, sx, sy;
            if (!following || !tv) return;
            tx = px + (tile_w >> 1) - (view_w >> 1);
            if (tx < 0) tx = 0;
            lim = map_w * tile_w - view_w;
            if (tx > lim) tx = lim;
            tx = sat16(tx);
            ty = py - ((view_h - tile_h) >>> 1);
            if (ty < 0) ty = 0;
            lim = map_h * tile_h - view_h;
            if (ty > lim) ty = lim;
            ty = sat16(ty);

            xd = tx - cam_x;
            yd = ty - cam_y;
            // already on target: a pending jump stays pending
            if (xd == 0 && yd == 0) return;
            if (jump_due) begin
                jump_due = 1'b0;
                cam_x = tx;
                cam_y = ty;
                return;
            end
            tp   = (speed * ft) >> 12;
            ax   = (xd < 0) ? -xd : xd;
            ay   = (yd < 0) ? -yd : yd;
            len2 = ax * ax + ay * ay;
            if (len2 < tp * tp) begin
                cam_x = tx;
                cam_y = ty;
            end else begin
                sx = axis_step(tp, ax, len2);
                sy = axis_step(tp, ay, len2);
                cam_x += (xd < 0) ? -int'(sx) : int'(sx);
                cam_y += (yd < 0) ? -int'(sy) : int'(sy);
            end
        endfunction

        function void accept_cmd(scf_in_t b);
            int       ox, oy;
            scf_out_t r;
            ox = cam_x;
            oy = cam_y;
            case (b.operation)
                OP_TICK: chase_target(int'($signed(b.pos_x)), int'($signed(b.pos_y)),
                                      b.target_valid, int'(b.frame_time));
                OP_SET_POS: begin
                    cam_x = sat16(int'($signed(b.pos_x)));
                    cam_y = sat16(int'($signed(b.pos_y)));
                    following = 1'b0;
                end
                OP_FOLLOW: begin
                    following = 1'b1;
                    jump_due = 1'b0;
                end
                OP_JUMP: jump_due = 1'b1;
                OP_RESET_POS: begin
                    cam_x = 0;
                    cam_y = 0;
                    jump_due = 1'b0;
                end
                default: ;
            endcase
            r.cam_x = cam_x[15:0];
            r.cam_y = cam_y[15:0];
            r.moved = (cam_x != ox) || (cam_y != oy);
            cam_due.push_back(r);
        endfunction

        function void compare_cam(scf_out_t got);
            scf_out_t exp_r;
            if (cam_due.size() == 0) begin
                $display("%0t unexpected result beat: cam_x %0d cam_y %0d moved %0b",
                         $time, got.cam_x, got.cam_y, got.moved);
                errors++;
                return;
            end
            exp_r = cam_due.pop_front();
            if (got.cam_x !== exp_r.cam_x) begin
                $display("%0t cam_x mismatch: expected %0d, got %0d",
                         $time, exp_r.cam_x, got.cam_x);
                errors++;
            end
            if (got.cam_y !== exp_r.cam_y) begin
                $display("%0t cam_y mismatch: expected %0d, got %0d",
                         $time, exp_r.cam_y, got.cam_y);
                errors++;
            end
            if (got.moved !== exp_r.moved) begin
                $display("%0t moved mismatch: expected %0b, got %0b",
                         $time, exp_r.moved, got.moved);
                errors++;
            end
        endfunction

        function int due_count();
            return cam_due.size();
        endfunction
    endclass

endpackage

/* sim/tb_scroll_camera_follow_unit.sv */
// top of the scroll camera follow unit bench: clock, reset, beat drivers and phased stimulus
// depends on scf_pkg, scf_camera_tracker_pkg and the scroll_camera_follow_unit rtl
module tb_scroll_camera_follow_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scf_pkg::*;
    import scf_camera_tracker_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 150;
    localparam int RANDOM_PER_PHASE = 290;
    localparam int NUM_PHASES       = 7;
    localparam int NUM_REGS         = 7;

    // codes the block does not decode
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    scf_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    scf_out_t               m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    camera_tracker tracker = new();
    int unsigned   reg_plan [NUM_REGS];
    int            burst_left = 0;
    int            ready_run = 0;
    int            stall_run = 0;
    int            quiet;

    scroll_camera_follow_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: runs of ready broken by stalls of random length
    always @(posedge aclk) begin
        if (stall_run > 0) begin
            m_ready <= 1'b0;
            stall_run--;
        end else if (ready_run > 0) begin
            m_ready <= 1'b1;
            ready_run--;
        end else begin
            ready_run = $urandom_range(1, 48);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            m_ready <= (stall_run == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.compare_cam(m_data);
    end

    initial begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic scf_in_t mk(logic [2:0] op, int x, int y, bit tv, int ft);
        scf_in_t b;
        b.operation    = op;
        b.pos_x        = 16'(x);
        b.pos_y        = 16'(y);
        b.target_valid = tv;
        b.frame_time   = 10'(ft);
        return b;
    endfunction

    function automatic scf_in_t pick_cmd();
        scf_in_t b;
        int      r, m;
        b.operation    = OP_TICK;
        b.pos_x        = 16'($urandom);
        b.pos_y        = 16'($urandom);
        b.target_valid = ($urandom_range(0, 9) != 0);
        b.frame_time   = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 40))
                                                     : 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 72) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    // target a short way from the camera, so snaps and small steps show up
                    m = ($urandom_range(0, 1) == 0) ? 64 : 600;
                    b.pos_x = 16'(tracker.cam_x + int'($urandom_range(0, 2 * m)) - m
                                  - (tracker.tile_w >> 1) + (tracker.view_w >> 1));
                    b.pos_y = 16'(tracker.cam_y + int'($urandom_range(0, 2 * m)) - m
                                  + ((tracker.view_h - tracker.tile_h) >>> 1));
                end
                2, 3: begin
                    b.pos_x = 16'($urandom_range(0, tracker.map_w * tracker.tile_w));
                    b.pos_y = 16'($urandom_range(0, tracker.map_h * tracker.tile_h));
                end
                default: ;
            endcase
        end else if (r < 78) begin
            b.operation = OP_FOLLOW;
        end else if (r < 84) begin
            b.operation = OP_JUMP;
        end else if (r < 89) begin
            b.operation = OP_SET_POS;
        end else if (r < 93) begin
            b.operation = OP_RESET_POS;
        end else begin
            b.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return b;
    endfunction

    task automatic send_beat(scf_in_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.accept_cmd(b);
    endtask

    // bursts of back-to-back beats, most of them followed by a gap
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.due_count() != 0);
        burst_left = 0;
    endtask

    task automatic load_config();
        int i;
        for (i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= scf_reg_t'(i);
            cfg_wdata <= CFG_DATA_W'(reg_plan[i]);
            @(posedge aclk);
            tracker.write_reg(scf_reg_t'(i), reg_plan[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        send_beat(mk(OP_TICK, 500, 500, 1'b1, 1023));          // not following yet
        send_beat(mk(OP_UNUSED_LO, -32768, 32767, 1'b1, 1023));
        send_beat(mk(OP_UNUSED_HI, 32767, -32768, 1'b0, 0));
        send_beat(mk(OP_SET_POS, 32767, -32768, 1'b0, 0));
        send_beat(mk(OP_SET_POS, -32768, 32767, 1'b1, 1023));
        send_beat(mk(OP_RESET_POS, 0, 0, 1'b0, 0));
        send_beat(mk(OP_FOLLOW, 0, 0, 1'b0, 0));
        send_beat(mk(OP_TICK, 800, 800, 1'b0, 1023));          // no target
        send_beat(mk(OP_TICK, 32767, 32767, 1'b1, 1023));      // full step toward far corner
        send_beat(mk(OP_TICK, -32768, -32768, 1'b1, 0));       // zero step length
        send_beat(mk(OP_JUMP, 0, 0, 1'b0, 0));
        send_beat(mk(OP_TICK, 1000, 500, 1'b1, 5));            // jump onto target
        send_beat(mk(OP_JUMP, 0, 0, 1'b0, 0));
        send_beat(mk(OP_TICK, 1000, 500, 1'b1, 5));            // on target, jump kept
        send_beat(mk(OP_TICK, 300, 200, 1'b1, 5));             // pending jump taken now
        send_beat(mk(OP_TICK, 310, 205, 1'b1, 1023));          // close enough to snap
        send_beat(mk(OP_SET_POS, 100, 100, 1'b0, 0));
        send_beat(mk(OP_TICK, 900, 900, 1'b1, 1023));          // set ended following
        send_beat(mk(OP_FOLLOW, 0, 0, 1'b0, 0));
        send_beat(mk(OP_TICK, 900, 900, 1'b1, 1));
        send_beat(mk(OP_RESET_POS, 0, 0, 1'b0, 0));            // following stays on
        send_beat(mk(OP_TICK, 'h5555, 'h2AAA, 1'b1, 'h2AA));
        send_beat(mk(OP_TICK, 'hAAAA, 'h5555, 1'b1, 'h155));
        send_beat(mk(OP_UNUSED_MID, 1, 1, 1'b1, 1));
    endtask

    initial begin
        int phase, n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: ;
                1: reg_plan = '{4095, 4095, 255, 255, 4095, 4095, 65535};
                2: reg_plan = '{1, 1, 1, 1, 1, 1, 0};
                // map smaller than the screen drives targets negative
                3: reg_plan = '{4095, 4095, 16, 16, 8, 8, 40000};
                6: reg_plan = '{RST_SCREEN_W, RST_SCREEN_H, RST_TILE_W, RST_TILE_H,
                                RST_MAP_W, RST_MAP_H, RST_SPEED};
                default: reg_plan = '{$urandom_range(1, 4095), $urandom_range(1, 4095),
                                      $urandom_range(1, 255), $urandom_range(1, 255),
                                      $urandom_range(1, 4095), $urandom_range(1, 4095),
                                      $urandom_range(0, 65535)};
            endcase
            if (phase != 0) load_config();
            send_beat(mk(OP_FOLLOW, 0, 0, 1'b0, 0));
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2) drain();
                pace_sender();
                send_beat(pick_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.due_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0t errors %0d, results still due %0d",
                     $time, tracker.errors, tracker.due_count());
            $display("status: fail");
        end
        $finish;
    end

endmodule
